// ----- src/ftpp_pkg.sv -----
// Shared types and constants for the file-transfer packet parser.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ftpp_pkg;

  // One accepted input transfer: a packet byte and its end-of-packet mark
  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       pkt_last;
  } ftpp_in_t;

  // One result transfer
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] write_offset;
    logic [7:0]  payload_byte;
    logic        name_match;
    logic        size_match;
  } ftpp_out_t;

  // Configuration register contents seen by the parser
  typedef struct packed {
    logic [7:0] data_type_code;
    logic [7:0] start_type_code;
    logic [7:0] end_type_code;
    logic [7:0] size_tag_code;
    logic [7:0] name_tag_code;
  } ftpp_cfg_t;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPORT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_DATA_TYPE  = 3'd0;
  localparam logic [2:0] REG_START_TYPE = 3'd1;
  localparam logic [2:0] REG_END_TYPE   = 3'd2;
  localparam logic [2:0] REG_SIZE_TAG   = 3'd3;
  localparam logic [2:0] REG_NAME_TAG   = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_DATA_TYPE  = 8'd1;
  localparam logic [7:0] RST_START_TYPE = 8'd2;
  localparam logic [7:0] RST_END_TYPE   = 8'd3;
  localparam logic [7:0] RST_SIZE_TAG   = 8'd0;
  localparam logic [7:0] RST_NAME_TAG   = 8'd1;

  // Last sequence number before the count wraps to zero; numbers count modulo 255
  localparam logic [7:0] SEQ_LAST = 8'd254;

endpackage

`default_nettype wire

// ----- src/ftpp_cfg_regs.sv -----
// APB-style configuration registers for the packet parser.
// Depends on ftpp_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module ftpp_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output ftpp_pkg::ftpp_cfg_t    cfg
);
  import ftpp_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_type_code  <= RST_DATA_TYPE;
      cfg.start_type_code <= RST_START_TYPE;
      cfg.end_type_code   <= RST_END_TYPE;
      cfg.size_tag_code   <= RST_SIZE_TAG;
      cfg.name_tag_code   <= RST_NAME_TAG;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DATA_TYPE:  cfg.data_type_code  <= pwdata[7:0];
        REG_START_TYPE: cfg.start_type_code <= pwdata[7:0];
        REG_END_TYPE:   cfg.end_type_code   <= pwdata[7:0];
        REG_SIZE_TAG:   cfg.size_tag_code   <= pwdata[7:0];
        REG_NAME_TAG:   cfg.name_tag_code   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_index)
      REG_DATA_TYPE:  prdata = {24'd0, cfg.data_type_code};
      REG_START_TYPE: prdata = {24'd0, cfg.start_type_code};
      REG_END_TYPE:   prdata = {24'd0, cfg.end_type_code};
      REG_SIZE_TAG:   prdata = {24'd0, cfg.size_tag_code};
      REG_NAME_TAG:   prdata = {24'd0, cfg.name_tag_code};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/ftpp_in_reg.sv -----
// Input register stage of the packet parser: holds one byte transfer.
// Depends on ftpp_pkg for the input struct.
`timescale 1ns / 1ps
`default_nettype none

module ftpp_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ftpp_pkg::ftpp_in_t in_item,
  input  wire logic              sink_ready,
  output logic                   step,
  output ftpp_pkg::ftpp_in_t     held_item
);
  import ftpp_pkg::*;

  logic held_valid;
  logic accept;

  // Held byte moves on whenever the result side can take its outcome
  assign step     = held_valid && sink_ready;
  assign in_stall = held_valid && !sink_ready;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= accept || (held_valid && !step);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/ftpp_parser.sv -----
// Parse state, name store and per-byte decode of the packet parser.
// Depends on ftpp_pkg for the item, result and config structs.
`timescale 1ns / 1ps
`default_nettype none

module ftpp_parser #(
  parameter int NAME_BYTES       = 256,
  parameter int SIZE_FIELD_BYTES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ftpp_pkg::ftpp_cfg_t cfg,
  input  wire logic                step,
  input  wire ftpp_pkg::ftpp_in_t  item,
  output logic                     res_load,
  output ftpp_pkg::ftpp_out_t      res
);
  import ftpp_pkg::*;

  localparam int         AW       = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int         SW       = 8 * SIZE_FIELD_BYTES;
  localparam logic [8:0] NAME_LIM = 9'(NAME_BYTES);
  localparam logic [8:0] SIZE_LIM = 9'(SIZE_FIELD_BYTES);

  typedef enum logic [3:0] {
    PH_TYPE, PH_SEQ, PH_LENH, PH_LENL, PH_DATA,
    PH_S_TAG, PH_S_LEN, PH_S_VAL,
    PH_E_TAG, PH_E_LEN, PH_E_VAL, PH_SKIP
  } phase_t;

  // Parse state
  phase_t      phase, phase_next;
  logic [7:0]  expected_sequence, expected_sequence_next;
  logic [15:0] declared_length, declared_length_next;
  logic        field_is_name, field_is_name_next;
  logic [7:0]  field_remaining, field_remaining_next;
  logic [7:0]  field_index, field_index_next;
  logic [7:0]  stored_name_length, stored_name_length_next;
  logic [SW-1:0] stored_file_size, stored_file_size_next;
  logic [SW-1:0] compare_size, compare_size_next;
  logic        name_equal_so_far, name_equal_so_far_next;
  logic        name_equal_flag, name_equal_flag_next;
  logic        size_equal_flag, size_equal_flag_next;
  logic [31:0] file_offset, file_offset_next;

  // Name store and its prefetched read word
  logic [7:0]    name_mem [NAME_BYTES];
  logic [7:0]    name_rd;
  logic          name_wr;
  logic [AW-1:0] name_wr_addr;
  logic [AW-1:0] name_rd_addr;

  logic [7:0] b;
  logic       in_name_range;
  logic       in_size_range;
  logic [SW-1:0] byte_lane;
  logic       tag_is_name;
  logic       tag_is_size;
  logic       end_done;
  logic       finish_field;

  assign b             = item.pkt_byte;
  assign in_name_range = {1'b0, field_index} < NAME_LIM;
  assign in_size_range = {1'b0, field_index} < SIZE_LIM;
  assign tag_is_name   = (b == cfg.name_tag_code);
  assign tag_is_size   = (b == cfg.size_tag_code);
  assign name_wr_addr  = field_index[AW-1:0];
  assign name_rd_addr  = field_index_next[AW-1:0];

  // Byte placed in its little-endian lane of the size field
  always_comb begin
    byte_lane = '0;
    for (int k = 0; k < SIZE_FIELD_BYTES; k++) begin
      if (field_index == 8'(k)) begin
        byte_lane[8*k +: 8] = b;
      end
    end
  end

  // Per-byte decode
  always_comb begin
    phase_next              = phase;
    expected_sequence_next  = expected_sequence;
    declared_length_next    = declared_length;
    field_is_name_next      = field_is_name;
    field_remaining_next    = field_remaining;
    field_index_next        = field_index;
    stored_name_length_next = stored_name_length;
    stored_file_size_next   = stored_file_size;
    compare_size_next       = compare_size;
    name_equal_so_far_next  = name_equal_so_far;
    name_equal_flag_next    = name_equal_flag;
    size_equal_flag_next    = size_equal_flag;
    file_offset_next        = file_offset;
    name_wr                 = 1'b0;
    end_done                = 1'b0;
    finish_field            = 1'b0;
    res_load                = 1'b0;
    res                     = '0;

    unique case (phase)
      PH_TYPE: begin
        name_equal_flag_next = 1'b0;
        size_equal_flag_next = 1'b0;
        // start beats end, end beats data when codes coincide
        priority if (b == cfg.start_type_code) begin
          phase_next = PH_S_TAG;
        end else if (b == cfg.end_type_code) begin
          phase_next = PH_E_TAG;
        end else if (b == cfg.data_type_code) begin
          phase_next = PH_SEQ;
        end else begin
          res.result_kind = KIND_REJECT;
          res_load        = 1'b1;
          phase_next      = PH_SKIP;
        end
      end
      PH_SEQ: begin
        if (b == expected_sequence) begin
          expected_sequence_next = (expected_sequence == SEQ_LAST) ? 8'd0
                                                                   : expected_sequence + 8'd1;
          phase_next = PH_LENH;
        end else begin
          res.result_kind = KIND_REJECT;
          res_load        = 1'b1;
          phase_next      = PH_SKIP;
        end
      end
      PH_LENH: begin
        declared_length_next = {b, 8'd0};
        phase_next           = PH_LENL;
      end
      PH_LENL: begin
        declared_length_next = {declared_length[15:8], b};
        phase_next           = ({declared_length[15:8], b} != 16'd0) ? PH_DATA : PH_SKIP;
      end
      PH_DATA: begin
        res.result_kind  = KIND_PAYLOAD;
        res.write_offset = file_offset;
        res.payload_byte = b;
        res_load         = 1'b1;
        if (file_offset != 32'hFFFF_FFFF) begin
          file_offset_next = file_offset + 32'd1;
        end
        declared_length_next = declared_length - 16'd1;
        if (declared_length == 16'd1) begin
          phase_next = PH_SKIP;
        end
      end
      PH_S_TAG, PH_E_TAG: begin
        // name tag beats size tag when codes coincide
        field_is_name_next = tag_is_name;
        if (!tag_is_name && !tag_is_size) begin
          res.result_kind = KIND_REJECT;
          res_load        = 1'b1;
          phase_next      = PH_SKIP;
        end else begin
          phase_next = (phase == PH_S_TAG) ? PH_S_LEN : PH_E_LEN;
        end
      end
      PH_S_LEN: begin
        field_remaining_next = b;
        declared_length_next = {8'd0, b};
        field_index_next     = 8'd0;
        if (field_is_name) begin
          stored_name_length_next = 8'd0;
        end else begin
          stored_file_size_next = '0;
        end
        phase_next = (b == 8'd0) ? PH_S_TAG : PH_S_VAL;
      end
      PH_S_VAL: begin
        if (field_is_name) begin
          name_wr                 = in_name_range;
          stored_name_length_next = stored_name_length + 8'd1;
        end else if (in_size_range) begin
          stored_file_size_next = stored_file_size | byte_lane;
        end
        field_index_next     = field_index + 8'd1;
        field_remaining_next = field_remaining - 8'd1;
        if (field_remaining == 8'd1) begin
          phase_next = PH_S_TAG;
        end
      end
      PH_E_LEN: begin
        field_remaining_next   = b;
        declared_length_next   = {8'd0, b};
        field_index_next       = 8'd0;
        compare_size_next      = '0;
        name_equal_so_far_next = 1'b1;
        if (b == 8'd0) begin
          finish_field = 1'b1;
          phase_next   = PH_E_TAG;
        end else begin
          phase_next = PH_E_VAL;
        end
      end
      PH_E_VAL: begin
        if (field_is_name) begin
          // name_rd was fetched for this index by the previous byte
          if (field_index >= stored_name_length) begin
            name_equal_so_far_next = 1'b0;
          end else if (in_name_range && (name_rd != b)) begin
            name_equal_so_far_next = 1'b0;
          end
        end else if (in_size_range) begin
          compare_size_next = compare_size | byte_lane;
        end
        field_index_next     = field_index + 8'd1;
        field_remaining_next = field_remaining - 8'd1;
        if (field_remaining == 8'd1) begin
          finish_field = 1'b1;
          phase_next   = PH_E_TAG;
        end
      end
      PH_SKIP: ;
      default: ;
    endcase

    // A completed field of an end packet sets its match flag
    if (finish_field) begin
      end_done = 1'b1;
      if (field_is_name) begin
        if (name_equal_so_far_next &&
            (declared_length_next == {8'd0, stored_name_length})) begin
          name_equal_flag_next = 1'b1;
        end
      end else if (compare_size_next == stored_file_size) begin
        size_equal_flag_next = 1'b1;
      end
    end

    // Report when the last byte of an end packet closes a field
    if (item.pkt_last && end_done) begin
      res.result_kind = KIND_REPORT;
      res.name_match  = name_equal_flag_next;
      res.size_match  = size_equal_flag_next;
      res_load        = 1'b1;
    end

    if (item.pkt_last) begin
      phase_next = PH_TYPE;
    end

    if (!step) begin
      res_load = 1'b0;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_TYPE;
      expected_sequence  <= 8'd0;
      declared_length    <= 16'd0;
      field_is_name      <= 1'b0;
      field_remaining    <= 8'd0;
      field_index        <= 8'd0;
      stored_name_length <= 8'd0;
      stored_file_size   <= '0;
      compare_size       <= '0;
      name_equal_so_far  <= 1'b0;
      name_equal_flag    <= 1'b0;
      size_equal_flag    <= 1'b0;
      file_offset        <= 32'd0;
    end else if (step) begin
      phase              <= phase_next;
      expected_sequence  <= expected_sequence_next;
      declared_length    <= declared_length_next;
      field_is_name      <= field_is_name_next;
      field_remaining    <= field_remaining_next;
      field_index        <= field_index_next;
      stored_name_length <= stored_name_length_next;
      stored_file_size   <= stored_file_size_next;
      compare_size       <= compare_size_next;
      name_equal_so_far  <= name_equal_so_far_next;
      name_equal_flag    <= name_equal_flag_next;
      size_equal_flag    <= size_equal_flag_next;
      file_offset        <= file_offset_next;
    end
  end

  // Name store: write during a start packet, prefetch the next compare byte
  always_ff @(posedge clk) begin
    if (step && name_wr) begin
      name_mem[name_wr_addr] <= b;
    end
    if (step) begin
      name_rd <= name_mem[name_rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/ftpp_out_reg.sv -----
// Result register of the packet parser: holds one result until it is taken.
// Depends on ftpp_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module ftpp_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire ftpp_pkg::ftpp_out_t load_item,
  output logic                     ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ftpp_pkg::ftpp_out_t      out_item
);
  import ftpp_pkg::*;

  // Free, or emptied by the transfer at this edge
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      out_item <= load_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/file_transfer_packet_parser_unit.sv -----
// File-transfer packet parser, top level.
// Depends on ftpp_pkg, ftpp_cfg_regs, ftpp_in_reg, ftpp_parser and ftpp_out_reg.
//
// Packet bytes arrive on the in channel (in_valid / in_stall / in_item), one byte
// per transfer, with pkt_last set on the final byte of each packet. Results leave
// on the out channel (out_valid / out_stall / out_item): a payload byte with its
// file offset, an end-packet report with name and size match flags, or a reject.
// A byte gives zero or one result.
// A byte is captured in the input register, decoded from there, and its result is
// loaded into the result register for the receiver (two register stages).
// Throughput: one byte per cycle while the receiver does not stall; the parse state
// update and the name-store read for the next byte are registered with the decode.
// If the receiver stalls, the result register holds and the input register takes
// one more byte only if it is empty; in_stall is then high until the result is taken.
// Reset (rst, synchronous) empties both stages, sets the parser to wait for a type
// byte, zeroes the sequence count, offset and stored name length and size, and
// loads the register defaults. The name store itself is not cleared. It is up to the
// user, not the block, to write configuration registers through the APB-style port while idle.
`timescale 1ns / 1ps
`default_nettype none

module file_transfer_packet_parser_unit #(
  parameter int NAME_BYTES       = 256,
  parameter int SIZE_FIELD_BYTES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ftpp_pkg::ftpp_in_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ftpp_pkg::ftpp_out_t      out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);
  import ftpp_pkg::*;

  ftpp_cfg_t cfg;
  ftpp_in_t  held_item;
  ftpp_out_t res;
  logic      step;
  logic      res_load;
  logic      sink_ready;

  ftpp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ftpp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .sink_ready (sink_ready),
    .step       (step),
    .held_item  (held_item)
  );

  ftpp_parser #(
    .NAME_BYTES       (NAME_BYTES),
    .SIZE_FIELD_BYTES (SIZE_FIELD_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step     (step),
    .item     (held_item),
    .res_load (res_load),
    .res      (res)
  );

  ftpp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_item (res),
    .ready     (sink_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- dv/tb_file_transfer_packet_parser_unit.sv -----
// Self-checking testbench for the file-transfer packet parser: directed packets,
// then random packet traffic under several code settings and idle and stall mixes.
// Depends on ftpp_pkg and file_transfer_packet_parser_unit.
`timescale 1ns / 1ps

module tb_file_transfer_packet_parser_unit;
  import ftpp_pkg::*;

  localparam int NAME_STORE_BYTES = 256;
  localparam int SIZE_BYTES       = 8;
  localparam int DRAIN_CYCLES     = 6;
  localparam int CYCLE_LIMIT      = 400000;

  // Parse phases of the predictor
  typedef enum logic [3:0] {
    ST_TYPE, ST_SEQ, ST_LENH, ST_LENL, ST_DATA, ST_S_TAG, ST_S_LEN, ST_S_VAL,
    ST_E_TAG, ST_E_LEN, ST_E_VAL, ST_SKIP
  } parse_phase_t;

  typedef enum logic [1:0] {FIELD_NONE, FIELD_NAME, FIELD_SIZE} field_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ftpp_in_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ftpp_out_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  file_transfer_packet_parser_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state, mirroring the parser
  ftpp_cfg_t    cfg = '{RST_DATA_TYPE, RST_START_TYPE, RST_END_TYPE, RST_SIZE_TAG,
                        RST_NAME_TAG};
  parse_phase_t phase = ST_TYPE;
  logic [7:0]   exp_seq = '0;
  logic [15:0]  decl_len = '0;
  field_t       field_kind = FIELD_NONE;
  logic [7:0]   field_rem = '0;
  logic [7:0]   name_store [NAME_STORE_BYTES];
  logic [7:0]   name_len = '0;
  logic [63:0]  file_size = '0;
  logic [63:0]  cmp_size = '0;
  logic         name_eq_so_far = 1'b0;
  logic         name_eq_flag = 1'b0;
  logic         size_eq_flag = 1'b0;
  logic [31:0]  file_offset = '0;

  ftpp_out_t    pending_results [$];
  ftpp_out_t    want;
  logic [7:0]   pkt_bytes [$];
  int           mismatch_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_file_transfer_packet_parser_unit: errors");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall = !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Closes a TLV of an end packet: latch the match flag for that field
  task automatic close_end_field();
    if (field_kind == FIELD_NAME) begin
      if (name_eq_so_far && decl_len == {8'h00, name_len}) name_eq_flag = 1'b1;
    end else if (cmp_size == file_size) begin
      size_eq_flag = 1'b1;
    end
  endtask

  // Predicts the result of one accepted byte and queues it
  task automatic parse_byte(input ftpp_in_t t);
    logic [7:0] b;
    int         idx;
    logic       end_done;
    logic       emit;
    ftpp_out_t  r;
    b = t.pkt_byte;
    end_done = 1'b0;
    emit = 1'b0;
    r = '0;
    idx = 0;
    case (phase)
      ST_TYPE: begin
        name_eq_flag = 1'b0;
        size_eq_flag = 1'b0;
        if (b == cfg.start_type_code) phase = ST_S_TAG;
        else if (b == cfg.end_type_code) phase = ST_E_TAG;
        else if (b == cfg.data_type_code) phase = ST_SEQ;
        else begin
          r.result_kind = KIND_REJECT;
          emit = 1'b1;
          phase = ST_SKIP;
        end
      end
      ST_SEQ: begin
        if (b == exp_seq) begin
          exp_seq = (exp_seq == SEQ_LAST) ? 8'd0 : exp_seq + 8'd1;
          phase = ST_LENH;
        end else begin
          r.result_kind = KIND_REJECT;
          emit = 1'b1;
          phase = ST_SKIP;
        end
      end
      ST_LENH: begin
        decl_len = {b, 8'h00};
        phase = ST_LENL;
      end
      ST_LENL: begin
        decl_len = decl_len | {8'h00, b};
        phase = (decl_len != 16'd0) ? ST_DATA : ST_SKIP;
      end
      ST_DATA: begin
        r.result_kind = KIND_PAYLOAD;
        r.write_offset = file_offset;
        r.payload_byte = b;
        emit = 1'b1;
        if (file_offset != 32'hFFFF_FFFF) file_offset++;
        decl_len--;
        if (decl_len == 16'd0) phase = ST_SKIP;
      end
      ST_S_TAG, ST_E_TAG: begin
        if (b == cfg.name_tag_code) field_kind = FIELD_NAME;
        else if (b == cfg.size_tag_code) field_kind = FIELD_SIZE;
        else field_kind = FIELD_NONE;
        if (field_kind == FIELD_NONE) begin
          r.result_kind = KIND_REJECT;
          emit = 1'b1;
          phase = ST_SKIP;
        end else begin
          phase = (phase == ST_S_TAG) ? ST_S_LEN : ST_E_LEN;
        end
      end
      ST_S_LEN: begin
        field_rem = b;
        decl_len = {8'h00, b};
        if (field_kind == FIELD_NAME) name_len = '0;
        else file_size = '0;
        phase = (b == 8'd0) ? ST_S_TAG : ST_S_VAL;
      end
      ST_S_VAL: begin
        idx = int'(decl_len) - int'(field_rem);
        if (field_kind == FIELD_NAME) begin
          if (idx < NAME_STORE_BYTES) name_store[idx] = b;
          name_len++;
        end else if (idx < SIZE_BYTES) begin
          file_size = file_size | ({56'h0, b} << (8 * idx));
        end
        field_rem--;
        if (field_rem == 8'd0) phase = ST_S_TAG;
      end
      ST_E_LEN: begin
        field_rem = b;
        decl_len = {8'h00, b};
        cmp_size = '0;
        name_eq_so_far = 1'b1;
        if (b == 8'd0) begin
          close_end_field();
          end_done = 1'b1;
          phase = ST_E_TAG;
        end else begin
          phase = ST_E_VAL;
        end
      end
      ST_E_VAL: begin
        idx = int'(decl_len) - int'(field_rem);
        if (field_kind == FIELD_NAME) begin
          if (idx >= int'(name_len)) name_eq_so_far = 1'b0;
          else if (idx < NAME_STORE_BYTES && name_store[idx] != b) name_eq_so_far = 1'b0;
        end else if (idx < SIZE_BYTES) begin
          cmp_size = cmp_size | ({56'h0, b} << (8 * idx));
        end
        field_rem--;
        if (field_rem == 8'd0) begin
          close_end_field();
          end_done = 1'b1;
          phase = ST_E_TAG;
        end
      end
      default: ;
    endcase
    // Report only when the final byte closes a TLV of an end packet
    if (t.pkt_last && end_done && !emit) begin
      r.result_kind = KIND_REPORT;
      r.name_match = name_eq_flag;
      r.size_match = size_eq_flag;
      emit = 1'b1;
    end
    if (t.pkt_last) phase = ST_TYPE;
    if (emit) pending_results.push_back(r);
  endtask

  task automatic check_field(input string label, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, label, want_v, got_v);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_item);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(out_item.result_kind));
        check_field("write_offset", want.write_offset, out_item.write_offset);
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_item.payload_byte));
        check_field("name_match", 32'(want.name_match), 32'(out_item.name_match));
        check_field("size_match", 32'(want.size_match), 32'(out_item.size_match));
      end
    end
  end

  // One byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_item.pkt_byte = b;
    in_item.pkt_last = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(in_item);
  endtask

  // Holds off the sender until every expected result has been taken
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sends the built packet; random packets may be cut short
  task automatic send_packet(input bit allow_cut);
    int unsigned count;
    count = pkt_bytes.size();
    if (allow_cut && count > 1 && $urandom_range(0, 9) == 0)
      count = $urandom_range(1, count - 1);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 299) == 0) wait_for_results();
      send_byte(pkt_bytes[i], i == count - 1);
    end
    bytes_sent += count;
    pkt_bytes.delete();
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = {24'h0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read back through a second access
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    case (index)
      REG_DATA_TYPE:  cfg.data_type_code = value;
      REG_START_TYPE: cfg.start_type_code = value;
      REG_END_TYPE:   cfg.end_type_code = value;
      REG_SIZE_TAG:   cfg.size_tag_code = value;
      REG_NAME_TAG:   cfg.name_tag_code = value;
      default: ;
    endcase
    if (readback !== {24'h0, value}) begin
      mismatch_count++;
      $display("%0t: register %0d readback expected %0h, got %0h", $time, index,
               {24'h0, value}, readback);
    end
  endtask

  task automatic set_codes(input logic [7:0] data_c, input logic [7:0] start_c,
                           input logic [7:0] end_c, input logic [7:0] size_t,
                           input logic [7:0] name_t);
    wait_for_results();
    write_reg(REG_DATA_TYPE, data_c);
    write_reg(REG_START_TYPE, start_c);
    write_reg(REG_END_TYPE, end_c);
    write_reg(REG_SIZE_TAG, size_t);
    write_reg(REG_NAME_TAG, name_t);
  endtask

  // Appends one TLV; a copy follows the stored name or size, mostly unaltered
  task automatic add_tlv(input bit copy);
    int unsigned sel;
    int unsigned n;
    logic [7:0]  t;
    logic [7:0]  v;
    sel = $urandom_range(0, 14);
    if (sel == 0) begin
      do t = rand_byte(); while (t == cfg.name_tag_code || t == cfg.size_tag_code);
      pkt_bytes.push_back(t);
      pkt_bytes.push_back(8'($urandom_range(0, 3)));
    end else if (sel < 8) begin
      if (copy) begin
        n = name_len;
        if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n + 1);
        if (n > 255) n = 255;
      end else begin
        n = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 6);
      end
      pkt_bytes.push_back(cfg.name_tag_code);
      pkt_bytes.push_back(8'(n));
      for (int unsigned i = 0; i < n; i++) begin
        v = (copy && i < name_len) ? name_store[i] : rand_byte();
        if ($urandom_range(0, 29) == 0) v = rand_byte();
        pkt_bytes.push_back(v);
      end
    end else begin
      if (copy) n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : SIZE_BYTES;
      else n = $urandom_range(0, 10);
      pkt_bytes.push_back(cfg.size_tag_code);
      pkt_bytes.push_back(8'(n));
      for (int unsigned i = 0; i < n; i++) begin
        v = (copy && i < SIZE_BYTES) ? file_size[8 * i +: 8] : rand_byte();
        if ($urandom_range(0, 29) == 0) v = rand_byte();
        pkt_bytes.push_back(v);
      end
    end
  endtask

  task automatic build_data_packet();
    int unsigned n;
    logic [15:0] len;
    logic [7:0]  seq;
    seq = exp_seq;
    if ($urandom_range(0, 9) == 0) seq = rand_byte();
    n = ($urandom_range(0, 24) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
    len = 16'(n);
    // length that disagrees with the bytes carried
    if ($urandom_range(0, 14) == 0) len = 16'($urandom_range(0, 65535));
    pkt_bytes.push_back(cfg.data_type_code);
    pkt_bytes.push_back(seq);
    pkt_bytes.push_back(len[15:8]);
    pkt_bytes.push_back(len[7:0]);
    repeat (n) pkt_bytes.push_back(rand_byte());
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) pkt_bytes.push_back(rand_byte());
  endtask

  task automatic add_random_packet();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      build_data_packet();
    end else if (pick < 85) begin
      pkt_bytes.push_back(pick < 65 ? cfg.start_type_code : cfg.end_type_code);
      repeat ($urandom_range(0, 3)) add_tlv(pick >= 65 && $urandom_range(0, 9) < 7);
    end else begin
      repeat ($urandom_range(1, 4)) pkt_bytes.push_back(rand_byte());
    end
    send_packet(1'b1);
  endtask

  // Unknown type bytes, including both extremes
  task automatic test_packet_types();
    pkt_bytes = {8'hFF, 8'h00};
    send_packet(1'b0);
    pkt_bytes = {8'h00};
    send_packet(1'b0);
  endtask

  // Payload bytes with offsets, extra trailing byte ignored
  task automatic test_data_packet();
    pkt_bytes = {cfg.data_type_code, exp_seq, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h5A};
    send_packet(1'b0);
  endtask

  // Wrong sequence, then a zero-length data packet
  task automatic test_bad_sequence();
    pkt_bytes = {cfg.data_type_code, 8'h07};
    send_packet(1'b0);
    pkt_bytes = {cfg.data_type_code, exp_seq, 8'h00, 8'h00};
    send_packet(1'b0);
  endtask

  // Start stores name and size; end compares, with an empty size field
  task automatic test_start_end_compare();
    pkt_bytes = {cfg.start_type_code, cfg.name_tag_code, 8'h01, 8'h41,
                 cfg.size_tag_code, 8'h01, 8'h34};
    send_packet(1'b0);
    pkt_bytes = {cfg.end_type_code, cfg.name_tag_code, 8'h01, 8'h41,
                 cfg.size_tag_code, 8'h00};
    send_packet(1'b0);
  endtask

  // Unknown TLV tag, and a data packet ending right after its sequence byte
  task automatic test_unknown_tag_and_short();
    pkt_bytes = {cfg.end_type_code, 8'h77};
    send_packet(1'b0);
    pkt_bytes = {cfg.data_type_code, exp_seq};
    send_packet(1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned target);
    int unsigned stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) add_random_packet();
  endtask

  // Walks the sequence number through its wrap; 255 is never a valid number
  task automatic test_sequence_wrap();
    int unsigned walked;
    walked = 0;
    while (walked < 256) begin
      if (exp_seq == SEQ_LAST) begin
        pkt_bytes = {cfg.data_type_code, SEQ_LAST + 8'd1};
        send_packet(1'b0);
      end
      pkt_bytes = {cfg.data_type_code, exp_seq};
      send_packet(1'b0);
      walked++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_packet_types();
    test_data_packet();
    test_bad_sequence();
    test_start_end_compare();
    test_unknown_tag_and_short();

    set_codes(8'hFF, 8'h00, 8'h80, 8'hFF, 8'h00);
    test_random_traffic(0, 0, 125);
    set_codes(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
    test_random_traffic(71, 0, 125);
    // small code range so that codes often collide
    set_codes(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
              8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
    test_random_traffic(0, 71, 125);
    set_codes(RST_DATA_TYPE, RST_START_TYPE, RST_END_TYPE, RST_SIZE_TAG, RST_NAME_TAG);
    test_random_traffic(38, 38, 125);
    test_sequence_wrap();

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("tb_file_transfer_packet_parser_unit: clean");
    end else begin
      $display("tb_file_transfer_packet_parser_unit: errors");
    end
    $finish;
  end

endmodule

// ----- file_transfer_packet_parser_unit.f -----
src/ftpp_pkg.sv
src/ftpp_cfg_regs.sv
src/ftpp_in_reg.sv
src/ftpp_parser.sv
src/ftpp_out_reg.sv
src/file_transfer_packet_parser_unit.sv
dv/tb_file_transfer_packet_parser_unit.sv
